@@ hdl/actc_pkg.sv @@
// actc_pkg: types and constants for the ansi color text cursor
// no dependencies; imported by ansi_color_text_cursor_top, actc_checker and tb_top

package actc_pkg;

   localparam int CHAR_W  = 8;
   localparam int POS_W   = 12;
   localparam int COLOR_W = 3;
   localparam int ARG_W   = 8;
   localparam int AIDX_W  = 2;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [ARG_W-1:0]   arg_type;
   typedef logic [AIDX_W-1:0]  aidx_type;
   typedef logic               csr_index_type;

   // register map
   localparam csr_index_type REG_LINE_WIDTH    = 1'b0;
   localparam csr_index_type REG_SCREEN_HEIGHT = 1'b1;

   localparam pos_type LINE_WIDTH_RST    = 12'd640;
   localparam pos_type SCREEN_HEIGHT_RST = 12'd480;

   // character codes
   localparam char_type CH_ESC     = 8'd27;
   localparam char_type CH_NEWLINE = 8'd10;
   localparam char_type CH_LBRACK  = 8'h5B;
   localparam char_type CH_SEMI    = 8'h3B;
   localparam char_type CH_M       = 8'h6D;
   localparam char_type CH_ZERO    = 8'h30;
   localparam char_type CH_NINE    = 8'h39;
   localparam char_type CH_UP_A    = 8'h41;
   localparam char_type CH_UP_Z    = 8'h5A;
   localparam char_type CH_LO_A    = 8'h61;
   localparam char_type CH_LO_Z    = 8'h7A;

   // sgr argument ranges
   localparam arg_type SGR_FG_LO = 8'd30;
   localparam arg_type SGR_FG_HI = 8'd37;
   localparam arg_type SGR_BG_LO = 8'd40;
   localparam arg_type SGR_BG_HI = 8'd47;

   localparam color_type FORE_RST = 3'd7;
   localparam color_type BACK_RST = 3'd0;

   localparam aidx_type AIDX_MAX = 2'd3;

   typedef struct packed {
      logic      draw;
      char_type  glyph;
      pos_type   pos_x;
      pos_type   pos_y;
      color_type fore_colour;
      color_type back_colour;
      logic      scroll;
   } result_type;

endpackage

@@ hdl/ansi_color_text_cursor_top.sv @@
// ansi_color_text_cursor_top: sgr escape parser and text cursor, one result per item
// single result register: an accepted item shows on rsp_* in the cycle after accept;
// one item per cycle unless stalled (parser and cursor update in the accept cycle)
// req_stall is high only while a result waits and rsp_stall is high
// reset: synchronous, clears parser, cursor, colors (white on black) and registers
// depends on actc_pkg

module ansi_color_text_cursor_top
   import actc_pkg::*;
#(
   parameter int CELL_SIZE = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  char_type      req_char_code,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic          rsp_draw,
   output char_type      rsp_glyph,
   output pos_type       rsp_pos_x,
   output pos_type       rsp_pos_y,
   output color_type     rsp_fore_colour,
   output color_type     rsp_back_colour,
   output logic          rsp_scroll,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  pos_type       csr_wdata
);

   // two spare bits cover position plus two cells
   localparam int SUM_W = POS_W + 2;
   localparam logic [SUM_W-1:0] CELL = SUM_W'(CELL_SIZE);

   pos_type    line_width_ff, screen_height_ff;
   logic       in_escape_ff, in_escape_in;
   aidx_type   arg_index_ff, arg_index_in;
   arg_type    first_arg_ff, first_arg_in;
   arg_type    second_arg_ff, second_arg_in;
   color_type  fore_ff, fore_in;
   color_type  back_ff, back_in;
   pos_type    cursor_x_ff, cursor_x_in;
   pos_type    cursor_y_ff, cursor_y_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff, result_in;

   logic       accept;
   logic       esc_path;
   logic       is_letter, is_digit;
   aidx_type   base_idx;
   arg_type    base_first, base_second;
   logic [3:0] digit;
   logic [SUM_W-1:0] nx, ny, ny_step;
   logic       wrap, scroll_req;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign esc_path  = (req_char_code == CH_ESC) || in_escape_ff;
   assign is_letter = (req_char_code >= CH_UP_A && req_char_code <= CH_UP_Z) ||
                      (req_char_code >= CH_LO_A && req_char_code <= CH_LO_Z);
   assign is_digit  = (req_char_code >= CH_ZERO) && (req_char_code <= CH_NINE);
   assign digit     = 4'(req_char_code - CH_ZERO);

   // opening an escape starts with cleared arguments
   assign base_idx    = in_escape_ff ? arg_index_ff  : '0;
   assign base_first  = in_escape_ff ? first_arg_ff  : '0;
   assign base_second = in_escape_ff ? second_arg_ff : '0;

   // cursor advance
   assign nx      = SUM_W'(cursor_x_ff) + CELL;
   assign wrap    = (nx >= SUM_W'(line_width_ff)) || (req_char_code == CH_NEWLINE);
   assign ny      = wrap ? SUM_W'(cursor_y_ff) + CELL : SUM_W'(cursor_y_ff);
   assign ny_step = ny + CELL;
   assign scroll_req = ny_step >= SUM_W'(screen_height_ff);

   always_comb begin
      in_escape_in  = in_escape_ff;
      arg_index_in  = arg_index_ff;
      first_arg_in  = first_arg_ff;
      second_arg_in = second_arg_ff;
      fore_in       = fore_ff;
      back_in       = back_ff;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      result_in     = '0;
      if (esc_path) begin
         in_escape_in  = 1'b1;
         arg_index_in  = base_idx;
         first_arg_in  = base_first;
         second_arg_in = base_second;
         if (is_letter) begin
            in_escape_in = 1'b0;
            if (req_char_code == CH_M) begin
               if (base_idx == '0 && base_first == '0) begin
                  fore_in = FORE_RST;
                  back_in = BACK_RST;
               end else if (base_idx == 2'd1) begin
                  if (base_second >= SGR_FG_LO && base_second <= SGR_FG_HI)
                     fore_in = COLOR_W'(base_second - SGR_FG_LO);
                  if (base_second >= SGR_BG_LO && base_second <= SGR_BG_HI)
                     back_in = COLOR_W'(base_second - SGR_BG_LO);
               end
            end
         end else if (req_char_code == CH_SEMI) begin
            if (base_idx != AIDX_MAX)
               arg_index_in = base_idx + 2'd1;
         end else if (is_digit) begin
            // arg * 10 + digit, wrapping at 8 bits
            if (base_idx == 2'd0)
               first_arg_in = (base_first << 3) + (base_first << 1) + ARG_W'(digit);
            else if (base_idx == 2'd1)
               second_arg_in = (base_second << 3) + (base_second << 1) + ARG_W'(digit);
         end
      end else begin
         result_in.draw        = 1'b1;
         result_in.glyph       = req_char_code;
         result_in.pos_x       = cursor_x_ff;
         result_in.pos_y       = cursor_y_ff;
         result_in.fore_colour = fore_ff;
         result_in.back_colour = back_ff;
         result_in.scroll      = scroll_req;
         cursor_x_in = wrap ? '0 : POS_W'(nx);
         if (scroll_req)
            cursor_y_in = (ny >= CELL) ? POS_W'(ny - CELL) : '0;
         else
            cursor_y_in = POS_W'(ny);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff    <= LINE_WIDTH_RST;
         screen_height_ff <= SCREEN_HEIGHT_RST;
         in_escape_ff     <= 1'b0;
         arg_index_ff     <= '0;
         first_arg_ff     <= '0;
         second_arg_ff    <= '0;
         fore_ff          <= FORE_RST;
         back_ff          <= BACK_RST;
         cursor_x_ff      <= '0;
         cursor_y_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               REG_LINE_WIDTH:    line_width_ff    <= csr_wdata;
               REG_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            in_escape_ff  <= in_escape_in;
            arg_index_ff  <= arg_index_in;
            first_arg_ff  <= first_arg_in;
            second_arg_ff <= second_arg_in;
            fore_ff       <= fore_in;
            back_ff       <= back_in;
            cursor_x_ff   <= cursor_x_in;
            cursor_y_ff   <= cursor_y_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept)
         result_ff <= result_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_draw        = result_ff.draw;
   assign rsp_glyph       = result_ff.glyph;
   assign rsp_pos_x       = result_ff.pos_x;
   assign rsp_pos_y       = result_ff.pos_y;
   assign rsp_fore_colour = result_ff.fore_colour;
   assign rsp_back_colour = result_ff.back_colour;
   assign rsp_scroll      = result_ff.scroll;

endmodule

@@ hdl/actc_checker.sv @@
// actc_checker: port-level assertions for ansi_color_text_cursor_top
// depends on actc_pkg; bound to the top level at the end of this file

module actc_checker
   import actc_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input char_type      req_char_code,
   input logic          rsp_valid,
   input logic          rsp_draw,
   input char_type      rsp_glyph,
   input pos_type       rsp_pos_x,
   input pos_type       rsp_pos_y,
   input color_type     rsp_fore_colour,
   input color_type     rsp_back_colour,
   input logic          rsp_scroll
);

   // an accepted item shows up on the result side in the following cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item produced no result");

   // an escape byte never draws
   a_esc_no_draw: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_char_code == CH_ESC |=> !rsp_draw)
      else $error("escape byte produced a draw");

   // non-draw results carry an all-zero payload
   a_idle_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_draw |-> rsp_glyph == '0 && rsp_pos_x == '0 && rsp_pos_y == '0 &&
         rsp_fore_colour == '0 && rsp_back_colour == '0 && !rsp_scroll)
      else $error("escape result payload not zero");

   // drawn glyphs never carry the escape code
   a_no_esc_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_draw |-> rsp_glyph != CH_ESC)
      else $error("escape code drawn as glyph");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ansi_color_text_cursor_top actc_checker u_actc_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking testbench for ansi_color_text_cursor_top, with a built-in
// escape parser and cursor predictor, random handshake idling and a long output hold
// depends on actc_pkg and ansi_color_text_cursor_top

module tb_top;
   import actc_pkg::*;

   localparam int CELL           = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 170;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   char_type      req_char_code = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_draw;
   char_type      rsp_glyph;
   pos_type       rsp_pos_x;
   pos_type       rsp_pos_y;
   color_type     rsp_fore_colour;
   color_type     rsp_back_colour;
   logic          rsp_scroll;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = REG_LINE_WIDTH;
   pos_type       csr_wdata = '0;

   // predictor state
   pos_type   cfg_line_width = LINE_WIDTH_RST;
   pos_type   cfg_screen_height = SCREEN_HEIGHT_RST;
   logic      esc_open = 1'b0;
   aidx_type  sgr_index = '0;
   arg_type   sgr_first = '0;
   arg_type   sgr_second = '0;
   color_type cur_fore = FORE_RST;
   color_type cur_back = BACK_RST;
   pos_type   cur_x = '0;
   pos_type   cur_y = '0;

   char_type   char_backlog[$];
   result_type due_results[$];
   int         bad_results = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   logic       hold_kick = 1'b0;
   int         hold_left = 0;
   int         quiet_cycles = 0;

   ansi_color_text_cursor_top #(
      .CELL_SIZE(CELL)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_draw(rsp_draw),
      .rsp_glyph(rsp_glyph),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_fore_colour(rsp_fore_colour),
      .rsp_back_colour(rsp_back_colour),
      .rsp_scroll(rsp_scroll),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // advance the parser and cursor by one character, return the draw command
   function automatic result_type cursor_step(char_type ch);
      result_type  r;
      int unsigned nx, ny;
      logic        is_letter;
      r = '0;
      is_letter = (ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z);
      if (ch == CH_ESC || esc_open) begin
         if (!esc_open) begin
            esc_open   = 1'b1;
            sgr_index  = '0;
            sgr_first  = '0;
            sgr_second = '0;
         end
         if (is_letter) begin
            if (ch == CH_M) begin
               if (sgr_index == 0 && sgr_first == 0) begin
                  cur_fore = FORE_RST;
                  cur_back = BACK_RST;
               end else if (sgr_index == 1) begin
                  if (sgr_second >= SGR_FG_LO && sgr_second <= SGR_FG_HI)
                     cur_fore = color_type'(sgr_second - SGR_FG_LO);
                  if (sgr_second >= SGR_BG_LO && sgr_second <= SGR_BG_HI)
                     cur_back = color_type'(sgr_second - SGR_BG_LO);
               end
            end
            esc_open = 1'b0;
         end else if (ch == CH_SEMI) begin
            if (sgr_index != AIDX_MAX)
               sgr_index = sgr_index + 1'b1;
         end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (sgr_index == 0)
               sgr_first = arg_type'(sgr_first * 10 + (ch - CH_ZERO));
            else if (sgr_index == 1)
               sgr_second = arg_type'(sgr_second * 10 + (ch - CH_ZERO));
         end
         return r;
      end
      r.draw        = 1'b1;
      r.glyph       = ch;
      r.pos_x       = cur_x;
      r.pos_y       = cur_y;
      r.fore_colour = cur_fore;
      r.back_colour = cur_back;
      nx = cur_x + CELL;
      ny = cur_y;
      if (nx >= cfg_line_width || ch == CH_NEWLINE) begin
         nx = 0;
         ny = cur_y + CELL;
      end
      if (ny + CELL >= cfg_screen_height) begin
         r.scroll = 1'b1;
         ny = (ny >= CELL) ? ny - CELL : 0;
      end
      cur_x = pos_type'(nx);
      cur_y = pos_type'(ny);
      return r;
   endfunction

   // character sender
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            due_results.push_back(cursor_step(req_char_code));
         if (!req_valid || !req_stall) begin
            if (char_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid     <= 1'b1;
               req_char_code <= char_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long output hold, counted here so the stimulus only has to kick it
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_kick)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // result checker
   always @(posedge clock) begin : result_check
      result_type seen, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_draw, rsp_glyph, rsp_pos_x, rsp_pos_y,
                    rsp_fore_colour, rsp_back_colour, rsp_scroll};
            if (due_results.size() == 0) begin
               bad_results++;
               if (bad_results <= 10)
                  $display("unexpected result: draw=%0d glyph=%0h x=%0d y=%0d",
                           seen.draw, seen.glyph, seen.pos_x, seen.pos_y);
            end else begin
               want = due_results.pop_front();
               if (seen !== want) begin
                  bad_results++;
                  if (bad_results <= 10)
                     $display({"mismatch: want draw=%0d glyph=%0h x=%0d y=%0d fg=%0d bg=%0d ",
                               "scroll=%0d, got draw=%0d glyph=%0h x=%0d y=%0d fg=%0d bg=%0d ",
                               "scroll=%0d"},
                              want.draw, want.glyph, want.pos_x, want.pos_y,
                              want.fore_colour, want.back_colour, want.scroll,
                              seen.draw, seen.glyph, seen.pos_x, seen.pos_y,
                              seen.fore_colour, seen.back_colour, seen.scroll);
               end
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[ansi_color_text_cursor_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++)
         char_backlog.push_back(char_type'(s[i]));
   endtask

   task automatic push_number(int unsigned v);
      push_text($sformatf("%0d", v));
   endtask

   function automatic char_type any_letter();
      if ($urandom_range(0, 1))
         return char_type'(CH_UP_A + $urandom_range(0, 25));
      return char_type'(CH_LO_A + $urandom_range(0, 25));
   endfunction

   // mostly text, newlines and well-formed color sequences, some broken escapes
   task automatic gen_traffic(int unsigned n_items);
      int unsigned base, pick, form;
      base = char_backlog.size();
      while (char_backlog.size() - base < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            char_backlog.push_back(char_type'($urandom_range(0, 255)));
         end else if (pick < 58) begin
            char_backlog.push_back(CH_NEWLINE);
         end else if (pick < 88) begin
            char_backlog.push_back(CH_ESC);
            char_backlog.push_back(CH_LBRACK);
            form = $urandom_range(0, 9);
            if (form == 0) begin
               push_text("0m");
            end else begin
               if (form < 7) begin
                  push_number($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9));
                  char_backlog.push_back(CH_SEMI);
                  push_number($urandom_range(30, 47));
               end else begin
                  push_number($urandom_range(0, 999));
                  char_backlog.push_back(CH_SEMI);
                  push_number($urandom_range(0, 999));
               end
               char_backlog.push_back($urandom_range(0, 4) == 0 ? any_letter() : CH_M);
            end
         end else begin
            char_backlog.push_back(CH_ESC);
            repeat ($urandom_range(1, 5)) begin
               case ($urandom_range(0, 4))
                  0: char_backlog.push_back(CH_SEMI);
                  1: char_backlog.push_back(char_type'(CH_ZERO + $urandom_range(0, 9)));
                  2: char_backlog.push_back(CH_ESC);
                  3: char_backlog.push_back(CH_LBRACK);
                  default: char_backlog.push_back(char_type'($urandom_range(0, 255)));
               endcase
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (char_backlog.size() != 0 || due_results.size() != 0 || req_valid)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // both registers back to back, valid stays up between them
   task automatic write_geometry(pos_type width, pos_type height);
      csr_valid <= 1'b1;
      csr_index <= REG_LINE_WIDTH;
      csr_wdata <= width;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_line_width = width;
      csr_index <= REG_SCREEN_HEIGHT;
      csr_wdata <= height;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_screen_height = height;
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(pos_type width, pos_type height, int idle_pct, int stall_pct,
                            logic with_hold);
      write_geometry(width, height);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (with_hold) begin
         hold_kick <= 1'b1;
         @(posedge clock);
         hold_kick <= 1'b0;
      end
      gen_traffic(PHASE_ITEMS);
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at the reset geometry
      char_backlog.push_back(8'd0);
      char_backlog.push_back(8'd255);
      push_text("\n");
      push_text("\033[0;35m");
      // second argument wraps to 44
      push_text("\033[;300m");
      // nested esc, separators up to the last argument index, ignored digit
      push_text("\033\033;;;7m");
      // other letter closes, the m after it is a plain glyph
      push_text("\033Xm");
      push_text("\033mZ");
      wait_drained();

      run_phase(12'd8, 12'd16, 0, 0, 1'b0);
      run_phase(12'd4095, 12'd4095, 61, 0, 1'b0);
      run_phase(12'd0, 12'd0, 0, 61, 1'b0);
      run_phase(pos_type'($urandom_range(8, 200)), pos_type'($urandom_range(16, 200)),
                28, 28, 1'b0);
      run_phase(12'd24, 12'd40, 28, 28, 1'b0);
      run_phase(LINE_WIDTH_RST, SCREEN_HEIGHT_RST, 0, 0, 1'b1);

      repeat (4) @(posedge clock);
      if (bad_results == 0 && due_results.size() == 0)
         $display("[ansi_color_text_cursor_top] OK");
      else
         $display("[ansi_color_text_cursor_top] ERROR");
      $finish;
   end

endmodule

@@ files.f @@
hdl/actc_pkg.sv
hdl/ansi_color_text_cursor_top.sv
hdl/actc_checker.sv
tb/sv/tb_top.sv
